>>> sv/dcep_pkg.sv
package dcep_pkg;

  // Record kinds carried on the master tuser.
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_LAST  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Decoded file types.
  localparam logic [2:0] FT_BASIC   = 3'd0;
  localparam logic [2:0] FT_NUM_ARR = 3'd1;
  localparam logic [2:0] FT_CHR_ARR = 3'd2;
  localparam logic [2:0] FT_CODE    = 3'd3;
  localparam logic [2:0] FT_PRINT   = 3'd4;
  localparam logic [2:0] FT_SEQ     = 3'd5;
  localparam logic [2:0] FT_DELETED = 3'd6;
  localparam logic [2:0] FT_UNKNOWN = 3'd7;

  localparam logic [7:0] MARK_END     = 8'h00;
  localparam logic [7:0] MARK_DELETED = 8'h01;
  localparam logic [7:0] CHAR_QMARK   = 8'h3F;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DEL     = 8'h7F;

  localparam logic [3:0] LAST_POS = 4'd15;

  localparam int SECTOR_W = 15;
  localparam int COUNT_W  = 8;
  localparam int USED_W   = 23;
  localparam int ODATA_W  = 176;

  // One finished piece of work handed from the front to the back.
  typedef struct packed {
    logic [1:0]              kind;
    logic                    deleted;
    logic [15:0][7:0]        bytes;
    logic [COUNT_W-1:0]      entry_count;
    logic [COUNT_W-1:0]      del_seen;
    logic [SECTOR_W-1:0]     sectors;
  } job_t;

  function automatic logic [2:0] decode_type(input logic [7:0] c);
    logic [2:0] t;
    t = FT_UNKNOWN;
    if (c == 8'h42) t = FT_BASIC;
    else if (c == 8'h44) t = FT_NUM_ARR;
    else if (c == 8'h43) t = FT_CODE;
    else if (c == 8'h23) t = FT_PRINT;
    else if (c == 8'h53) t = FT_SEQ;
    else if (c >= 8'h41 && c <= 8'h5A) t = FT_NUM_ARR;
    else if (c >= 8'h61 && c <= 8'h7A) t = FT_CHR_ARR;
    return t;
  endfunction

endpackage

>>> sv/dcep_front.sv
module dcep_front #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  logic              ready,
  input  logic [7:0]        cat_byte,
  input  logic              first_byte,
  output logic              push,
  output dcep_pkg::job_t    job
);
  import dcep_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_ENTRIES);

  logic [7:0]          entry_bytes [15];
  logic [3:0]          pos;
  logic [COUNT_W-1:0]  entry_total;
  logic [COUNT_W-1:0]  deleted_total;
  logic [SECTOR_W-1:0] sector_total;
  logic                finished;

  logic [3:0]          pos_eff;
  logic [COUNT_W-1:0]  entry_eff, deleted_eff, entry_next, deleted_next;
  logic [SECTOR_W-1:0] sector_eff, sector_next;
  logic                fin_eff, is_end, is_last, del, accept, full_now;

  always_comb begin
    accept      = valid && ready;
    pos_eff     = first_byte ? 4'd0 : pos;
    entry_eff   = first_byte ? '0 : entry_total;
    deleted_eff = first_byte ? '0 : deleted_total;
    sector_eff  = first_byte ? '0 : sector_total;
    fin_eff     = first_byte ? 1'b0 : finished;
    is_end      = !fin_eff && (pos_eff == 4'd0) && (cat_byte == MARK_END);
    is_last     = !fin_eff && !is_end && (pos_eff == LAST_POS);
    del         = (entry_bytes[0] == MARK_DELETED);
    entry_next  = entry_eff + 1'b1;
    deleted_next = del ? deleted_eff + 1'b1 : deleted_eff;
    sector_next = del ? sector_eff : sector_eff + SECTOR_W'(entry_bytes[13]);
    full_now    = (entry_next >= MaxCount);
    push        = accept && (is_end || is_last);

    job.deleted = del;
    for (int k = 0; k < 15; k++) job.bytes[k] = entry_bytes[k];
    job.bytes[15] = cat_byte;
    priority if (is_end) begin
      job.kind        = KIND_END;
      job.entry_count = entry_eff;
      job.del_seen    = deleted_eff;
      job.sectors     = sector_eff;
    end else begin
      job.kind        = full_now ? KIND_LAST : KIND_ENTRY;
      job.entry_count = entry_next;
      job.del_seen    = deleted_next;
      job.sectors     = sector_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !fin_eff && (pos_eff != LAST_POS)) begin
      entry_bytes[pos_eff] <= cat_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      entry_total   <= '0;
      deleted_total <= '0;
      sector_total  <= '0;
      finished      <= 1'b0;
    end else if (accept) begin
      priority if (fin_eff || is_end) begin
        pos <= pos_eff;
      end else if (is_last) begin
        pos <= 4'd0;
      end else begin
        pos <= pos_eff + 4'd1;
      end
      entry_total   <= is_last ? entry_next : entry_eff;
      deleted_total <= is_last ? deleted_next : deleted_eff;
      sector_total  <= is_last ? sector_next : sector_eff;
      finished      <= fin_eff || is_end || (is_last && full_now);
    end
  end

  // A stopped parser always sits at the start of an entry.
  a_fin_pos: assert property (@(posedge clk) disable iff (rst)
    finished |-> (pos == 4'd0))
    else $error("finished with nonzero byte position");

  a_entry_cap: assert property (@(posedge clk) disable iff (rst)
    entry_total <= MaxCount)
    else $error("entry total beyond catalog size");

  a_del_cap: assert property (@(posedge clk) disable iff (rst)
    deleted_total <= entry_total)
    else $error("more deleted entries than entries");

endmodule

>>> sv/dcep_queue.sv
module dcep_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dcep_pkg::job_t  push_job,
  input  logic            pop,
  output logic            not_empty,
  output logic            not_full,
  output dcep_pkg::job_t  head
);
  import dcep_pkg::*;

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign not_full  = (count != 2'd2);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (not_full || pop))
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

endmodule

>>> sv/dcep_back.sv
module dcep_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  dcep_pkg::job_t               job,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dcep_pkg::ODATA_W-1:0] m_tdata,
  output logic [1:0]                   m_tuser
);
  import dcep_pkg::*;

  logic [7:0]          src   [8];
  logic [7:0]          chr   [8];
  logic [7:0]          alive;
  logic [7:0]          solid;
  logic [7:0]          keep;
  logic [63:0]         name;
  logic                is_end;
  logic [2:0]          ftype;
  logic [ODATA_W-1:0]  data_next;

  always_comb begin
    is_end = (job.kind == KIND_END);
    // A deleted entry's first character is a fixed '?', which neither ends
    // the name nor gets trimmed, so it flows through the common path.
    for (int k = 0; k < 8; k++) begin
      src[k] = job.bytes[k];
    end
    if (job.deleted) src[0] = CHAR_QMARK;
    for (int k = 0; k < 8; k++) begin
      chr[k] = (src[k] >= CHAR_SPACE && src[k] < CHAR_DEL) ? src[k] : CHAR_QMARK;
    end
    // alive: no NUL at or before this position.
    alive[0] = (src[0] != 8'h00);
    for (int k = 1; k < 8; k++) alive[k] = alive[k-1] && (src[k] != 8'h00);
    // solid: some live non-space character at or after this position.
    solid[7] = alive[7] && (chr[7] != CHAR_SPACE);
    for (int k = 6; k >= 0; k--) begin
      solid[k] = solid[k+1] || (alive[k] && (chr[k] != CHAR_SPACE));
    end
    keep = alive & solid;
    for (int k = 0; k < 8; k++) name[k*8 +: 8] = keep[k] ? chr[k] : 8'h00;

    ftype = job.deleted ? FT_DELETED : decode_type(job.bytes[8]);

    data_next = '0;
    if (!is_end) begin
      data_next[63:0]    = name;
      data_next[71:64]   = job.bytes[8];
      data_next[74:72]   = ftype;
      data_next[90:75]   = {job.bytes[10], job.bytes[9]};
      data_next[106:91]  = {job.bytes[12], job.bytes[11]};
      data_next[114:107] = job.bytes[13];
      data_next[122:115] = job.bytes[14];
      data_next[130:123] = job.bytes[15];
    end
    data_next[138:131] = job.entry_count;
    data_next[146:139] = job.del_seen;
    data_next[169:147] = {job.sectors, 8'h00};

    pop = job_valid && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= data_next;
      m_tuser <= job.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_ENTRY || m_tuser == KIND_LAST || m_tuser == KIND_END))
    else $error("illegal record kind");

  a_end_blank: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_END) |-> (m_tdata[130:0] == '0))
    else $error("end record carries entry fields");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[146:139] <= m_tdata[138:131]))
    else $error("deleted count exceeds file count");

endmodule

>>> sv/disk_catalog_entry_parser_unit.sv
// Catalog parser for a TR-DOS style disk image. Catalog bytes arrive one per
// transfer on the slave stream and group into 16-byte entries; a record
// comes out on the master stream when the 16th byte of an entry arrives, or
// when an entry starts with a zero byte (end record with the totals only).
// Setting tuser on a byte restarts the parse and clears the totals; after
// the end record, or after the entry that fills MAX_ENTRIES slots, bytes
// are dropped until the next restart. The block takes one byte per cycle
// while the queue has room. A record appears on the master side once the
// front has registered the finished entry into a two-deep queue and the
// back has formatted it into the output register. If the master side
// stalls, the queue absorbs two records before the slave side is held off.
module disk_catalog_entry_parser_unit #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  // Slave stream: one catalog byte per transfer.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] cat_byte
  input  logic [0:0]                   s_tuser,   // [0] first_byte
  // Master stream: one record per transfer.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [63:0] name_chars, [71:64] ext_char, [74:72] file_type,
  // [90:75] start_or_line, [106:91] length_bytes, [114:107] sector_len,
  // [122:115] first_sector, [130:123] first_track, [138:131] files_seen,
  // [146:139] del_seen, [169:147] space_used, [175:170] zero
  output logic [dcep_pkg::ODATA_W-1:0] m_tdata,
  output logic [1:0]                   m_tuser    // [1:0] record_kind
);
  import dcep_pkg::*;

  logic push, pop, q_not_empty, q_not_full;
  job_t push_job, head_job;

  // The front is held off whenever the queue cannot take another record.
  assign s_tready = q_not_full;

  dcep_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (s_tvalid),
    .ready      (s_tready),
    .cat_byte   (s_tdata),
    .first_byte (s_tuser[0]),
    .push       (push),
    .job        (push_job)
  );

  dcep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .not_empty (q_not_empty),
    .not_full  (q_not_full),
    .head      (head_job)
  );

  dcep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_not_empty),
    .job       (head_job),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
